// ----- hdl/sha1_pkg.sv -----
// Shared constants and types of the SHA-1 hash engine.
`default_nettype none
package sha1_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned WordW   = 32;
  localparam int unsigned NumH    = 5;
  localparam int unsigned BlkB    = 64;
  localparam int unsigned BlkW    = BlkB * ByteW;
  localparam int unsigned FillW   = $clog2(BlkB);
  localparam int unsigned LenW    = 64;
  localparam int unsigned NumRnd  = 80;
  localparam int unsigned RndW    = $clog2(NumRnd);
  localparam int unsigned WnumW   = 3;

  typedef logic [WordW-1:0] word_t;
  typedef logic [NumH-1:0][WordW-1:0] chain_t;

  localparam chain_t HInit = {32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE,
                              32'hEFCDAB89, 32'h67452301};

  localparam word_t K0 = 32'h5A827999;
  localparam word_t K1 = 32'h6ED9EBA1;
  localparam word_t K2 = 32'h8F1BBCDC;
  localparam word_t K3 = 32'hCA62C1D6;

  localparam logic [ByteW-1:0] PadMark = 8'h80;
  localparam logic [FillW-1:0] LenPos  = FillW'(56);
  localparam logic [FillW-1:0] FillTop = FillW'(BlkB - 1);
  localparam logic [RndW-1:0]  LastRnd = RndW'(NumRnd - 1);
  localparam logic [WnumW-1:0] LastWord = WnumW'(NumH - 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_COMP,
    ST_ADD,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic             push;
    logic [ByteW-1:0] push_byte;
    logic             load;
    logic             round;
    logic [RndW-1:0]  rnd;
    logic             add;
    logic             init;
    logic             oload;
  } ctrl_t;

endpackage
`default_nettype wire

// ----- hdl/sha1_if.sv -----
// Handshake channel interfaces for message bytes and digest words.
`default_nettype none
interface sha1_in_if import sha1_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [ByteW-1:0] data_byte;
  logic             byte_valid;
  logic             end_of_message;

  modport source (output valid, data_byte, byte_valid, end_of_message, input ready);
  modport sink   (input valid, data_byte, byte_valid, end_of_message, output ready);
endinterface

interface sha1_out_if import sha1_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [WordW-1:0] digest_word;
  logic [WnumW-1:0] word_number;
  logic             last_word;

  modport source (output valid, digest_word, word_number, last_word, input ready);
  modport sink   (input valid, digest_word, word_number, last_word, output ready);
endinterface
`default_nettype wire

// ----- hdl/sha1_blk.sv -----
// Block buffer: gathers bytes, then serves as the 16-word message schedule window.
`default_nettype none
module sha1_blk import sha1_pkg::*; (
  input  wire logic  clk_i,
  input  wire ctrl_t ctrl_i,
  output word_t      w_o
);

  logic [BlkW-1:0] win_q;
  word_t           w0, w2, w8, w13, wx;

  // word j of the window sits at the top minus 32*j; word 0 is the oldest
  always_comb begin
    w0  = win_q[BlkW-1 -: WordW];
    w2  = win_q[BlkW-1-2*WordW -: WordW];
    w8  = win_q[BlkW-1-8*WordW -: WordW];
    w13 = win_q[BlkW-1-13*WordW -: WordW];
    wx  = w13 ^ w8 ^ w2 ^ w0;
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.push) begin
      win_q <= {win_q[BlkW-ByteW-1:0], ctrl_i.push_byte};
    end else if (ctrl_i.round) begin
      // advance: drop the word in use, append the next expanded word
      win_q <= {win_q[BlkW-WordW-1:0], wx[WordW-2:0], wx[WordW-1]};
    end
  end

  assign w_o = w0;

endmodule
`default_nettype wire

// ----- hdl/sha1_cmp.sv -----
// Shared round unit with working variables and chaining words.
`default_nettype none
module sha1_cmp import sha1_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire ctrl_t ctrl_i,
  input  wire word_t w_i,
  output chain_t     chain_o
);

  chain_t h_q;
  word_t  a_q, b_q, c_q, d_q, e_q;
  word_t  f, k, t;

  always_comb begin
    if (ctrl_i.rnd < RndW'(20)) begin
      f = (b_q & c_q) | (~b_q & d_q);
      k = K0;
    end else if (ctrl_i.rnd < RndW'(40)) begin
      f = b_q ^ c_q ^ d_q;
      k = K1;
    end else if (ctrl_i.rnd < RndW'(60)) begin
      f = (b_q & c_q) | (b_q & d_q) | (c_q & d_q);
      k = K2;
    end else begin
      f = b_q ^ c_q ^ d_q;
      k = K3;
    end
    t = {a_q[WordW-6:0], a_q[WordW-1 -: 5]} + f + e_q + k + w_i;
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      a_q <= h_q[0];
      b_q <= h_q[1];
      c_q <= h_q[2];
      d_q <= h_q[3];
      e_q <= h_q[4];
    end else if (ctrl_i.round) begin
      e_q <= d_q;
      d_q <= c_q;
      c_q <= {b_q[1:0], b_q[WordW-1:2]};
      b_q <= a_q;
      a_q <= t;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      h_q <= HInit;
    end else if (ctrl_i.init) begin
      h_q <= HInit;
    end else if (ctrl_i.add) begin
      h_q[0] <= h_q[0] + a_q;
      h_q[1] <= h_q[1] + b_q;
      h_q[2] <= h_q[2] + c_q;
      h_q[3] <= h_q[3] + d_q;
      h_q[4] <= h_q[4] + e_q;
    end
  end

  assign chain_o = h_q;

endmodule
`default_nettype wire

// ----- hdl/sha1_ctrl.sv -----
// Sequencer: byte intake, padding, round count and digest hand-off.
`default_nettype none
module sha1_ctrl import sha1_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  input  wire logic [ByteW-1:0] data_byte_i,
  input  wire logic             byte_valid_i,
  input  wire logic             eom_i,
  input  wire logic             out_busy_i,
  output logic                  in_ready_o,
  output ctrl_t                 ctrl_o
);

  state_e            state_q, state_d;
  logic [FillW-1:0]  fill_q, fill_d;
  logic [LenW-1:0]   bits_q, bits_d, len_q, len_d, bits_inc;
  logic              mark_q, mark_d, lenph_q, lenph_d;
  logic              pad_q, pad_d, final_q, final_d;
  logic [RndW-1:0]   rnd_q, rnd_d;
  logic              len_byte;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      fill_q  <= '0;
      bits_q  <= '0;
      mark_q  <= 1'b0;
      lenph_q <= 1'b0;
      pad_q   <= 1'b0;
      final_q <= 1'b0;
      rnd_q   <= '0;
    end else begin
      state_q <= state_d;
      fill_q  <= fill_d;
      bits_q  <= bits_d;
      mark_q  <= mark_d;
      lenph_q <= lenph_d;
      pad_q   <= pad_d;
      final_q <= final_d;
      rnd_q   <= rnd_d;
    end
  end

  always_ff @(posedge clk_i) begin
    len_q <= len_d;
  end

  always_comb begin
    state_d  = state_q;
    fill_d   = fill_q;
    bits_d   = bits_q;
    len_d    = len_q;
    mark_d   = mark_q;
    lenph_d  = lenph_q;
    pad_d    = pad_q;
    final_d  = final_q;
    rnd_d    = rnd_q;
    in_ready_o = 1'b0;
    ctrl_o   = '0;
    ctrl_o.rnd = rnd_q;
    bits_inc = bits_q + LenW'(ByteW);
    len_byte = mark_q && (lenph_q || fill_q == LenPos);

    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (byte_valid_i) begin
            ctrl_o.push      = 1'b1;
            ctrl_o.push_byte = data_byte_i;
            bits_d = bits_inc;
            fill_d = fill_q + FillW'(1);
          end
          if (eom_i) begin
            len_d   = byte_valid_i ? bits_inc : bits_q;
            pad_d   = 1'b1;
            mark_d  = 1'b0;
            lenph_d = 1'b0;
            final_d = 1'b0;
          end
          if (byte_valid_i && fill_q == FillTop) begin
            ctrl_o.load = 1'b1;
            rnd_d   = '0;
            state_d = ST_COMP;
          end else if (eom_i) begin
            state_d = ST_PAD;
          end
        end
      end
      ST_PAD: begin
        ctrl_o.push = 1'b1;
        fill_d = fill_q + FillW'(1);
        if (!mark_q) begin
          ctrl_o.push_byte = PadMark;
          mark_d = 1'b1;
        end else if (len_byte) begin
          ctrl_o.push_byte = len_q[LenW-1 -: ByteW];
          len_d   = {len_q[LenW-ByteW-1:0], {ByteW{1'b0}}};
          lenph_d = 1'b1;
        end else begin
          ctrl_o.push_byte = '0;
        end
        if (fill_q == FillTop) begin
          ctrl_o.load = 1'b1;
          final_d = len_byte;
          rnd_d   = '0;
          state_d = ST_COMP;
        end
      end
      ST_COMP: begin
        ctrl_o.round = 1'b1;
        rnd_d = rnd_q + RndW'(1);
        if (rnd_q == LastRnd) begin
          state_d = ST_ADD;
        end
      end
      ST_ADD: begin
        ctrl_o.add = 1'b1;
        priority if (final_q) begin
          state_d = ST_DONE;
        end else if (pad_q) begin
          state_d = ST_PAD;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_DONE: begin
        // hold the digest until the output buffer has drained
        if (!out_busy_i) begin
          ctrl_o.oload = 1'b1;
          ctrl_o.init  = 1'b1;
          fill_d  = '0;
          bits_d  = '0;
          pad_d   = 1'b0;
          final_d = 1'b0;
          mark_d  = 1'b0;
          lenph_d = 1'b0;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

// ----- hdl/sha1_hash_engine_unit.sv -----
// Top level of the SHA-1 hash engine: sequencer, block window, round unit, digest buffer.
// Throughput: a byte beat per cycle while a block fills; the 64th byte starts 80 rounds
//   and then the chain add, and no byte is taken until both are through.
// After an end beat: padding bytes fill the block, each padded block (one or two) runs its
//   rounds and chain add, the digest is handed off, then five word beats leave their buffer.
// Reset (rst_ni low, asynchronous): empty message, initial chaining words, no digest pending.
`default_nettype none
module sha1_hash_engine_unit import sha1_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  sha1_in_if.sink   in_i,
  sha1_out_if.source out_o
);

  ctrl_t            ctrl;
  word_t            w;
  chain_t           chain;
  chain_t           obuf_q;
  logic [WnumW-1:0] ocnt_q;
  logic             obusy_q;
  logic             obeat;

  // Sequencer: accepts byte beats, inserts padding, counts rounds.
  sha1_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_i.valid),
    .data_byte_i  (in_i.data_byte),
    .byte_valid_i (in_i.byte_valid),
    .eom_i        (in_i.end_of_message),
    .out_busy_i   (obusy_q),
    .in_ready_o   (in_i.ready),
    .ctrl_o       (ctrl)
  );

  // Byte gather register doubling as the schedule window.
  sha1_blk u_blk (
    .clk_i  (clk_i),
    .ctrl_i (ctrl),
    .w_o    (w)
  );

  // One round per cycle, then add into the chaining words.
  sha1_cmp u_cmp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (ctrl),
    .w_i     (w),
    .chain_o (chain)
  );

  assign obeat = out_o.valid && out_o.ready;

  // Digest buffer: load all five words, then shift one out per beat.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      obusy_q <= 1'b0;
      ocnt_q  <= '0;
    end else if (ctrl.oload) begin
      obusy_q <= 1'b1;
      ocnt_q  <= '0;
    end else if (obeat) begin
      ocnt_q <= ocnt_q + WnumW'(1);
      if (ocnt_q == LastWord) begin
        obusy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.oload) begin
      obuf_q <= chain;
    end else if (obeat) begin
      obuf_q <= {word_t'('0), obuf_q[NumH-1:1]};
    end
  end

  assign out_o.valid       = obusy_q;
  assign out_o.digest_word = obuf_q[0];
  assign out_o.word_number = ocnt_q;
  assign out_o.last_word   = (ocnt_q == LastWord);

endmodule
`default_nettype wire
